// ----- hdl/chv_pkg.sv -----
// shared types and constants for the convex hull vertex counter
// no dependencies
package chv_pkg;

    localparam int HULL_COUNT_BITS = 11;

    // result of one call of the shared turn unit
    typedef struct packed {
        logic pos;       // a -> b -> c turns counter-clockwise
        logic zero;      // a, b, c collinear
        logic b_nearer;  // |b - a| < |c - a| in manhattan distance
        logic b_at_a;    // b coincides with a
        logic c_at_a;    // c coincides with a
    } chv_turn_res_t;

endpackage

// ----- hdl/chv_if.sv -----
// valid/ready channel interfaces for points in and hull results out
// depends on chv_pkg
interface chv_point_if #(parameter int COORD_BITS = 21) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;

    modport source (output valid, x, y, last, input ready);
    modport sink (input valid, x, y, last, output ready);
endinterface

interface chv_result_if import chv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [HULL_COUNT_BITS-1:0] hull_count;
    logic                       overflow;

    modport source (output valid, hull_count, overflow, input ready);
    modport sink (input valid, hull_count, overflow, output ready);
endinterface

// ----- hdl/chv_turn_unit.sv -----
// shared turn unit: sign of the cross product of (b - a) and (c - a), plus
// manhattan distances of b and c from a; one multiplier
// depends on chv_pkg
module chv_turn_unit
    import chv_pkg::*;
#(
    parameter int COORD_BITS = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         done,
    output chv_turn_res_t                res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = DW + 1;

    typedef enum logic [1:0] {U_IDLE, U_MUL1, U_MUL2, U_CMP} ustate_t;

    ustate_t               step_reg;
    logic                  done_reg;
    chv_turn_res_t         res_reg;
    logic signed [DW-1:0]  dbx_reg, dby_reg, dcx_reg, dcy_reg;
    logic signed [PW-1:0]  prod1_reg, prod2_reg;
    logic [SW-1:0]         dist_b_reg, dist_c_reg;
    logic signed [DW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;

    function automatic logic [SW-1:0] abs_ext(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        begin
            m = v[DW-1] ? DW'(-v) : DW'(v);
            return {1'b0, m};
        end
    endfunction

    assign mul_a = (step_reg == U_MUL1) ? dbx_reg : dby_reg;
    assign mul_b = (step_reg == U_MUL1) ? dcy_reg : dcx_reg;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= U_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == U_CMP);
            unique case (step_reg)
                U_IDLE: if (start) step_reg <= U_MUL1;
                U_MUL1: step_reg <= U_MUL2;
                U_MUL2: step_reg <= U_CMP;
                U_CMP: step_reg <= U_IDLE;
                default: step_reg <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == U_IDLE && start)
        begin
            dbx_reg <= $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
            dby_reg <= $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
            dcx_reg <= $signed({cx[COORD_BITS-1], cx}) - $signed({ax[COORD_BITS-1], ax});
            dcy_reg <= $signed({cy[COORD_BITS-1], cy}) - $signed({ay[COORD_BITS-1], ay});
        end
        if (step_reg == U_MUL1)
        begin
            prod1_reg  <= mul_p;
            dist_b_reg <= abs_ext(dbx_reg) + abs_ext(dby_reg);
            dist_c_reg <= abs_ext(dcx_reg) + abs_ext(dcy_reg);
        end
        if (step_reg == U_MUL2)
            prod2_reg <= mul_p;
        if (step_reg == U_CMP)
        begin
            res_reg.pos      <= prod1_reg > prod2_reg;
            res_reg.zero     <= prod1_reg == prod2_reg;
            res_reg.b_nearer <= dist_b_reg < dist_c_reg;
            res_reg.b_at_a   <= dist_b_reg == '0;
            res_reg.c_at_a   <= dist_c_reg == '0;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- hdl/convex_hull_vertex_count.sv -----
// convex hull vertex counter, top level: point store, angular insertion sort,
// graham scan; depends on chv_pkg, chv_if and chv_turn_unit
//
//  channel   role  payload                 handshake
//  points    sink  x, y, last              valid / ready
//  result    src   hull_count, overflow    valid / ready
//
// a set of n points loads at one item per cycle; then the insertion sort runs n-1 to
// n(n-1)/2 compare steps; each compare step and each turn test of the scan waits on
// the shared turn unit and on the single read port of each store. points is not ready
// from the last item until the result is registered. reset is asynchronous and needs
// no clearing pass. a stalled result holds while the next set loads; the next result
// waits for it.
module convex_hull_vertex_count
    import chv_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    chv_point_if.sink     points,
    chv_result_if.source  result
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);

    typedef enum logic [5:0] {
        S_LOAD, S_WAIT, S_UNIT,
        S_SORT_I, S_SORT_KEY, S_SORT_K, S_SORT_J, S_SORT_JPT, S_SORT_CMP,
        S_RUN_INIT, S_RUN_TOP, S_RUN_TOPPT, S_RUN_LO, S_RUN_J, S_RUN_JPT, S_RUN_CHK,
        S_REV, S_REV_A, S_REV_B, S_REV_W,
        S_SCAN_I, S_SCAN_P, S_SCAN_PPT, S_SCAN_TOP, S_SCAN_DUP, S_SCAN_POP,
        S_SCAN_A, S_SCAN_APT, S_SCAN_B, S_SCAN_BPT, S_SCAN_T, S_PUSH,
        S_FIN, S_FIN_CHK, S_DONE
    } state_t;

    state_t state_reg, ret_reg;

    logic signed [COORD_BITS-1:0] pt_x_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pt_y_mem [MAX_POINTS];
    logic [IW-1:0]                ord_mem [MAX_POINTS];
    logic [IW-1:0]                stk_mem [MAX_POINTS];

    logic                         pt_we_reg, ord_we_reg, stk_we_reg;
    logic                         pt_we_next, ord_we_next, stk_we_next;
    logic [IW-1:0]                pt_wa_reg, ord_wa_reg, stk_wa_reg;
    logic signed [COORD_BITS-1:0] pt_wx_reg, pt_wy_reg;
    logic [IW-1:0]                ord_wd_reg, stk_wd_reg;
    logic [IW-1:0]                pt_ra_reg, ord_ra_reg, stk_ra_reg;
    logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q;
    logic [IW-1:0]                ord_q, stk_q;

    logic [CW-1:0] cnt_reg, n_reg, i_reg, k_reg, lo_reg, hi_reg, sd_reg;
    logic          ovf_reg, rev_reg, fin_reg, start_reg, start_next;
    logic [IW-1:0] key_reg, j_reg, t1_reg, p_reg;
    logic signed [COORD_BITS-1:0] piv_x_reg, piv_y_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    logic                       res_valid_reg, res_valid_next, res_ovf_reg;
    logic [HULL_COUNT_BITS-1:0] res_count_reg;

    logic [CW-1:0] nm1, km1, lom1, sdm1, sdm2;
    logic          accept, take_pivot, unit_done;
    chv_turn_res_t unit_res;

    assign accept = points.valid && points.ready;
    assign nm1    = n_reg - 1'b1;
    assign km1    = k_reg - 1'b1;
    assign lom1   = lo_reg - 1'b1;
    assign sdm1   = sd_reg - 1'b1;
    assign sdm2   = sd_reg - 2'd2;
    assign take_pivot = (cnt_reg == '0) || (points.y < piv_y_reg) ||
                        (points.y == piv_y_reg && points.x < piv_x_reg);

    assign points.ready      = (state_reg == S_LOAD);
    assign result.valid      = res_valid_reg;
    assign result.hull_count = res_count_reg;
    assign result.overflow   = res_ovf_reg;

    // store write strobes, unit start and result valid
    always_comb
    begin
        pt_we_next  = accept && (cnt_reg != CW'(MAX_POINTS));
        ord_we_next = (state_reg == S_SORT_K && k_reg == '0) || (state_reg == S_SORT_CMP) ||
                      (state_reg == S_REV_B) || (state_reg == S_REV_W);
        stk_we_next = (state_reg == S_PUSH);
        start_next  = (state_reg == S_SORT_JPT) || (state_reg == S_RUN_JPT) ||
                      (state_reg == S_SCAN_BPT);
        if (state_reg == S_DONE && (!res_valid_reg || result.ready))
            res_valid_next = 1'b1;
        else if (result.valid && result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    chv_turn_unit #(.COORD_BITS(COORD_BITS)) u_turn (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .bx    (bx_reg),
        .by    (by_reg),
        .cx    (cx_reg),
        .cy    (cy_reg),
        .done  (unit_done),
        .res   (unit_res)
    );

    always_ff @(posedge clk)
    begin
        if (pt_we_reg)
        begin
            pt_x_mem[pt_wa_reg] <= pt_wx_reg;
            pt_y_mem[pt_wa_reg] <= pt_wy_reg;
        end
        pt_x_q <= pt_x_mem[pt_ra_reg];
        pt_y_q <= pt_y_mem[pt_ra_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we_reg)
            ord_mem[ord_wa_reg] <= ord_wd_reg;
        ord_q <= ord_mem[ord_ra_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we_reg)
            stk_mem[stk_wa_reg] <= stk_wd_reg;
        stk_q <= stk_mem[stk_ra_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            ret_reg       <= S_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            piv_x_reg     <= '0;
            piv_y_reg     <= '0;
            sd_reg        <= '0;
            pt_we_reg     <= 1'b0;
            ord_we_reg    <= 1'b0;
            stk_we_reg    <= 1'b0;
            start_reg     <= 1'b0;
            rev_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pt_we_reg     <= pt_we_next;
            ord_we_reg    <= ord_we_next;
            stk_we_reg    <= stk_we_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;

            unique case (state_reg)
                S_LOAD:
                    if (accept)
                    begin
                        if (cnt_reg != CW'(MAX_POINTS))
                        begin
                            pt_wa_reg <= cnt_reg[IW-1:0];
                            pt_wx_reg <= points.x;
                            pt_wy_reg <= points.y;
                            cnt_reg   <= cnt_reg + 1'b1;
                            if (take_pivot)
                            begin
                                piv_x_reg <= points.x;
                                piv_y_reg <= points.y;
                            end
                        end
                        else
                            ovf_reg <= 1'b1;
                        if (points.last)
                        begin
                            n_reg     <= (cnt_reg != CW'(MAX_POINTS)) ? cnt_reg + 1'b1
                                                                       : cnt_reg;
                            i_reg     <= '0;
                            state_reg <= S_SORT_I;
                        end
                    end
                S_WAIT: state_reg <= ret_reg;
                S_UNIT: if (unit_done) state_reg <= ret_reg;

                // insertion sort by angle, nearer first
                S_SORT_I:
                    if (i_reg == n_reg)
                        state_reg <= S_RUN_INIT;
                    else
                    begin
                        key_reg   <= i_reg[IW-1:0];
                        k_reg     <= i_reg;
                        pt_ra_reg <= i_reg[IW-1:0];
                        ret_reg   <= S_SORT_KEY;
                        state_reg <= S_WAIT;
                    end
                S_SORT_KEY:
                begin
                    bx_reg    <= pt_x_q;
                    by_reg    <= pt_y_q;
                    state_reg <= S_SORT_K;
                end
                S_SORT_K:
                    if (k_reg == '0)
                    begin
                        ord_wa_reg <= '0;
                        ord_wd_reg <= key_reg;
                        i_reg      <= i_reg + 1'b1;
                        state_reg  <= S_SORT_I;
                    end
                    else
                    begin
                        ord_ra_reg <= km1[IW-1:0];
                        ret_reg    <= S_SORT_J;
                        state_reg  <= S_WAIT;
                    end
                S_SORT_J:
                begin
                    j_reg     <= ord_q;
                    pt_ra_reg <= ord_q;
                    ret_reg   <= S_SORT_JPT;
                    state_reg <= S_WAIT;
                end
                S_SORT_JPT:
                begin
                    ax_reg    <= piv_x_reg;
                    ay_reg    <= piv_y_reg;
                    cx_reg    <= pt_x_q;
                    cy_reg    <= pt_y_q;
                    ret_reg   <= S_SORT_CMP;
                    state_reg <= S_UNIT;
                end
                S_SORT_CMP:
                begin
                    ord_wa_reg <= k_reg[IW-1:0];
                    if (unit_res.pos || (unit_res.zero && unit_res.b_nearer))
                    begin
                        ord_wd_reg <= j_reg;
                        k_reg      <= km1;
                        state_reg  <= S_SORT_K;
                    end
                    else
                    begin
                        ord_wd_reg <= key_reg;
                        i_reg      <= i_reg + 1'b1;
                        state_reg  <= S_SORT_I;
                    end
                end

                // trailing run on the last ray is taken farthest first
                S_RUN_INIT:
                begin
                    ord_ra_reg <= nm1[IW-1:0];
                    lo_reg     <= nm1;
                    hi_reg     <= nm1;
                    rev_reg    <= 1'b0;
                    ret_reg    <= S_RUN_TOP;
                    state_reg  <= S_WAIT;
                end
                S_RUN_TOP:
                begin
                    pt_ra_reg <= ord_q;
                    ret_reg   <= S_RUN_TOPPT;
                    state_reg <= S_WAIT;
                end
                S_RUN_TOPPT:
                begin
                    ax_reg    <= piv_x_reg;
                    ay_reg    <= piv_y_reg;
                    cx_reg    <= pt_x_q;
                    cy_reg    <= pt_y_q;
                    state_reg <= S_RUN_LO;
                end
                S_RUN_LO:
                    if (lo_reg == '0)
                        state_reg <= S_REV;
                    else
                    begin
                        ord_ra_reg <= lom1[IW-1:0];
                        ret_reg    <= S_RUN_J;
                        state_reg  <= S_WAIT;
                    end
                S_RUN_J:
                begin
                    pt_ra_reg <= ord_q;
                    ret_reg   <= S_RUN_JPT;
                    state_reg <= S_WAIT;
                end
                S_RUN_JPT:
                begin
                    bx_reg    <= pt_x_q;
                    by_reg    <= pt_y_q;
                    ret_reg   <= S_RUN_CHK;
                    state_reg <= S_UNIT;
                end
                S_RUN_CHK:
                    if (!unit_res.b_at_a && unit_res.zero)
                    begin
                        lo_reg    <= lom1;
                        state_reg <= S_RUN_LO;
                    end
                    else
                    begin
                        rev_reg   <= !unit_res.b_at_a && !unit_res.c_at_a;
                        state_reg <= S_REV;
                    end
                S_REV:
                    if (!rev_reg || lo_reg >= hi_reg)
                    begin
                        sd_reg    <= '0;
                        i_reg     <= '0;
                        fin_reg   <= 1'b0;
                        state_reg <= S_SCAN_I;
                    end
                    else
                    begin
                        ord_ra_reg <= lo_reg[IW-1:0];
                        ret_reg    <= S_REV_A;
                        state_reg  <= S_WAIT;
                    end
                S_REV_A:
                begin
                    t1_reg     <= ord_q;
                    ord_ra_reg <= hi_reg[IW-1:0];
                    ret_reg    <= S_REV_B;
                    state_reg  <= S_WAIT;
                end
                S_REV_B:
                begin
                    ord_wa_reg <= lo_reg[IW-1:0];
                    ord_wd_reg <= ord_q;
                    state_reg  <= S_REV_W;
                end
                S_REV_W:
                begin
                    ord_wa_reg <= hi_reg[IW-1:0];
                    ord_wd_reg <= t1_reg;
                    lo_reg     <= lo_reg + 1'b1;
                    hi_reg     <= hi_reg - 1'b1;
                    state_reg  <= S_REV;
                end

                // graham scan over the sorted order
                S_SCAN_I:
                    if (i_reg == n_reg)
                        state_reg <= S_FIN;
                    else
                    begin
                        ord_ra_reg <= i_reg[IW-1:0];
                        ret_reg    <= S_SCAN_P;
                        state_reg  <= S_WAIT;
                    end
                S_SCAN_P:
                begin
                    p_reg     <= ord_q;
                    pt_ra_reg <= ord_q;
                    ret_reg   <= S_SCAN_PPT;
                    state_reg <= S_WAIT;
                end
                S_SCAN_PPT:
                begin
                    cx_reg <= pt_x_q;
                    cy_reg <= pt_y_q;
                    if (sd_reg == '0)
                        state_reg <= S_PUSH;
                    else
                    begin
                        stk_ra_reg <= sdm1[IW-1:0];
                        ret_reg    <= S_SCAN_TOP;
                        state_reg  <= S_WAIT;
                    end
                end
                S_SCAN_TOP:
                begin
                    pt_ra_reg <= stk_q;
                    ret_reg   <= S_SCAN_DUP;
                    state_reg <= S_WAIT;
                end
                S_SCAN_DUP:
                    if (pt_x_q == cx_reg && pt_y_q == cy_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SCAN_I;
                    end
                    else
                        state_reg <= S_SCAN_POP;
                S_SCAN_POP:
                    if (sd_reg < CW'(2))
                        state_reg <= S_PUSH;
                    else
                    begin
                        stk_ra_reg <= sdm2[IW-1:0];
                        ret_reg    <= S_SCAN_A;
                        state_reg  <= S_WAIT;
                    end
                S_SCAN_A:
                begin
                    pt_ra_reg <= stk_q;
                    ret_reg   <= S_SCAN_APT;
                    state_reg <= S_WAIT;
                end
                S_SCAN_APT:
                begin
                    ax_reg     <= pt_x_q;
                    ay_reg     <= pt_y_q;
                    stk_ra_reg <= sdm1[IW-1:0];
                    ret_reg    <= S_SCAN_B;
                    state_reg  <= S_WAIT;
                end
                S_SCAN_B:
                begin
                    pt_ra_reg <= stk_q;
                    ret_reg   <= S_SCAN_BPT;
                    state_reg <= S_WAIT;
                end
                S_SCAN_BPT:
                begin
                    bx_reg    <= pt_x_q;
                    by_reg    <= pt_y_q;
                    ret_reg   <= S_SCAN_T;
                    state_reg <= S_UNIT;
                end
                S_SCAN_T:
                    if (fin_reg)
                    begin
                        if (unit_res.pos)
                            state_reg <= S_DONE;
                        else
                        begin
                            sd_reg    <= sdm1;
                            state_reg <= S_FIN_CHK;
                        end
                    end
                    else if (unit_res.pos)
                        state_reg <= S_PUSH;
                    else
                    begin
                        sd_reg    <= sdm1;
                        state_reg <= S_SCAN_POP;
                    end
                S_PUSH:
                begin
                    stk_wa_reg <= sd_reg[IW-1:0];
                    stk_wd_reg <= p_reg;
                    sd_reg     <= sd_reg + 1'b1;
                    i_reg      <= i_reg + 1'b1;
                    state_reg  <= S_SCAN_I;
                end

                // closing pops against the pivot
                S_FIN:
                begin
                    cx_reg    <= piv_x_reg;
                    cy_reg    <= piv_y_reg;
                    fin_reg   <= 1'b1;
                    state_reg <= S_FIN_CHK;
                end
                S_FIN_CHK:
                    if (sd_reg < CW'(3))
                        state_reg <= S_DONE;
                    else
                    begin
                        stk_ra_reg <= sdm2[IW-1:0];
                        ret_reg    <= S_SCAN_A;
                        state_reg  <= S_WAIT;
                    end
                S_DONE:
                    if (!res_valid_reg || result.ready)
                    begin
                        res_count_reg <= HULL_COUNT_BITS'(sd_reg);
                        res_ovf_reg   <= ovf_reg;
                        cnt_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_LOAD;
                    end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

// ----- hdl/chv_checker.sv -----
// port-level checks for the convex hull vertex counter, bound to the top level
// depends on chv_pkg and convex_hull_vertex_count
module chv_checker
    import chv_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [HULL_COUNT_BITS-1:0] hull_count,
    input logic                       overflow
);

    // a closing item starts the hull work, so no item is taken right after it
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("point taken right after a closing item");

    // every set holds at least one point
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hull_count != '0)
        else $error("result with zero hull vertices");

    // a new result comes only out of the busy phase
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while loading points");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hull_count) && $stable(overflow))
        else $error("stalled result changed");

endmodule

bind convex_hull_vertex_count chv_checker u_chv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (points.valid),
    .in_ready   (points.ready),
    .in_last    (points.last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .hull_count (result.hull_count),
    .overflow   (result.overflow)
);
